// ===== sv/rfc_pkg.sv =====
// Package for the radiation force convolution block.
// Holds opcodes, sequencer states, pipeline tag type and fixed widths.
// No dependencies.
package rfc_pkg;

   localparam int DOF   = 6;
   localparam int NCH   = 3;
   localparam int ACC_W = 32 * NCH;
   localparam int TOT_W = ACC_W + 34;

   typedef enum logic [1:0] {
      OP_LOAD_KERNEL = 2'd0,
      OP_LOAD_MASS   = 2'd1,
      OP_MOTION      = 2'd2,
      OP_CLEAR       = 2'd3
   } op_type;

   localparam logic CSR_KERNEL_LENGTH = 1'b0;
   localparam logic CSR_TIME_STEP     = 1'b1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_PUSH,
      S_CONV,
      S_MASS,
      S_DRAIN_A,
      S_SCALE,
      S_DRAIN_B,
      S_ROUND,
      S_SAT,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      M_CONV,
      M_MASS,
      M_SCALE
   } mode_type;

   typedef struct packed {
      logic       vld;
      mode_type   mode;
      logic       dbl;
      logic [1:0] chunk;
   } tag_type;

endpackage

// ===== sv/rfc_mul.sv =====
// Shared registered 33x33 signed multiplier with a tag that travels alongside.
// Depends on rfc_pkg.
module rfc_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  logic signed [32:0]   a,
   input  logic signed [32:0]   b,
   input  rfc_pkg::tag_type     tag_in,
   output logic signed [65:0]   p_ff,
   output rfc_pkg::tag_type     tag_ff
);
   import rfc_pkg::*;

   always_ff @(posedge clock) begin
      p_ff <= a * b;
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

endmodule

// ===== sv/radiation_force_convolution.sv =====
// Radiation force block: trapezoidal convolution of velocity history with a 6x6 kernel
// plus added mass, on one shared multiplier. Depends on rfc_pkg and rfc_mul.
//
// A motion beat on component 5 pushes the velocity vector into the history and then
// produces six force beats. Each row takes 6*N kernel products (N taps in use), six
// added-mass products and the three 32-bit slices of the time-step scaling, all through
// the single registered 33x33 multiplier at one product per cycle, plus pipeline drains,
// rounding and output. The block holds req_tready low until the sixth force beat has
// been taken. No clearing pass is needed after reset.
module radiation_force_convolution #(
   parameter int MAX_TAPS  = 256,
   parameter int FRAC_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic          csr_index,
   input  logic [31:0]   csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   // tap, row, col, coefficient, velocity, acceleration (lowest bit up), zero padded
   input  logic [111:0]  req_tdata,
   // op
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // force_row, force_res (lowest bit up), zero padded
   output logic [39:0]   rsp_tdata,
   // saturated
   output logic          rsp_tuser,
   output logic          rsp_tlast
);
   import rfc_pkg::*;

   localparam int TW  = (MAX_TAPS > 2) ? $clog2(MAX_TAPS) : 1;
   localparam int LW  = $clog2(MAX_TAPS + 1);
   localparam int KAW = $clog2(MAX_TAPS * 36);
   localparam int HAW = $clog2(MAX_TAPS * 6);
   localparam int HD  = MAX_TAPS * 6;
   localparam int KD  = MAX_TAPS * 36;

   logic [7:0]         in_tap;
   logic [2:0]         in_row;
   logic [2:0]         in_col;
   logic signed [31:0] in_coef;
   logic signed [31:0] in_vel;
   logic signed [31:0] in_acc;
   op_type             in_op;
   logic               accept;

   assign in_tap  = req_tdata[7:0];
   assign in_row  = req_tdata[10:8];
   assign in_col  = req_tdata[13:11];
   assign in_coef = req_tdata[45:14];
   assign in_vel  = req_tdata[77:46];
   assign in_acc  = req_tdata[109:78];
   assign in_op   = op_type'(req_tuser);

   logic [8:0]  kl_ff;
   logic [31:0] ts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         kl_ff <= 9'd1;
         ts_ff <= 32'd65536;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_KERNEL_LENGTH: kl_ff <= csr_wdata[8:0];
            CSR_TIME_STEP:     ts_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic signed [31:0] kern_mem [KD];
   logic signed [31:0] hist_mem [HD];
   logic signed [31:0] am_mem [36];
   logic signed [31:0] pv_ff [DOF];
   logic signed [31:0] pa_ff [DOF];

   state_type state_ff, state_in;
   logic [LW-1:0]  fill_ff, fill_in;
   logic [TW-1:0]  head_ff, head_in;
   logic [HAW-1:0] head6_ff, head6_in;
   logic [LW-1:0]  n_ff, n_in;
   logic [TW-1:0]  k_ff, k_in;
   logic [2:0]     j_ff, j_in;
   logic [2:0]     r_ff, r_in;
   logic [5:0]     r6_ff, r6_in;
   logic [1:0]     c_ff, c_in;
   logic [KAW-1:0] kbase_ff, kbase_in;
   logic [HAW-1:0] slot6_ff, slot6_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic signed [TOT_W-1:0] tot_ff, tot_in;
   logic signed [TOT_W-1:0] rnd_ff, rnd_in;
   logic signed [31:0]      res_ff, res_in;
   logic                    sat_ff, sat_in;

   logic [LW-1:0]  len_c;
   logic [LW-1:0]  fill_nx;
   logic [TW-1:0]  head_nx;
   tag_type        issue_tag, s1_ff, s2_tag;
   logic [KAW-1:0] k_raddr;
   logic [HAW-1:0] h_raddr;
   logic [5:0]     a_raddr;
   logic signed [31:0] kern_rd_ff, hist_rd_ff, am_rd_ff, pa_rd_ff;
   logic [31:0]        chunk_ff;
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod;
   logic               pipe_busy;
   logic               k_last;
   logic signed [TOT_W-1:0] sh;
   logic                    all0, all1;

   always_comb begin
      if (kl_ff == 9'd0) begin
         len_c = LW'(1);
      end else if (32'(kl_ff) > MAX_TAPS) begin
         len_c = LW'(MAX_TAPS);
      end else begin
         len_c = LW'(kl_ff);
      end
      fill_nx = (fill_ff < len_c) ? fill_ff + LW'(1) : fill_ff;
      head_nx = (32'(head_ff) == MAX_TAPS - 1) ? '0 : head_ff + TW'(1);
   end

   assign accept    = req_tvalid && req_tready;
   assign pipe_busy = s1_ff.vld || s2_tag.vld;
   assign k_last    = (LW'(k_ff) == n_ff - LW'(1));
   assign k_raddr   = kbase_ff + KAW'(r6_ff) + KAW'(j_ff);
   assign h_raddr   = slot6_ff + HAW'(j_ff);
   assign a_raddr   = r6_ff + 6'(j_ff);

   always_ff @(posedge clock) begin
      if (accept && in_op == OP_LOAD_KERNEL && in_row < 3'd6 && in_col < 3'd6
          && 32'(in_tap) < MAX_TAPS) begin
         kern_mem[KAW'(32'(in_tap) * 36 + 32'(in_row) * 6 + 32'(in_col))] <= in_coef;
      end
      if (accept && in_op == OP_LOAD_MASS && in_row < 3'd6 && in_col < 3'd6) begin
         am_mem[6'(in_row) * 6'd6 + 6'(in_col)] <= in_coef;
      end
      if (accept && in_op == OP_MOTION && in_col < 3'd6) begin
         pv_ff[in_col] <= in_vel;
         pa_ff[in_col] <= in_acc;
      end
      if (state_ff == S_PUSH) begin
         hist_mem[head6_ff + HAW'(j_ff)] <= pv_ff[j_ff];
      end
      kern_rd_ff <= kern_mem[k_raddr];
      hist_rd_ff <= hist_mem[h_raddr];
      am_rd_ff   <= am_mem[a_raddr];
      pa_rd_ff   <= pa_ff[j_ff];
      chunk_ff   <= acc_ff[32 * c_ff +: 32];
   end

   always_comb begin
      issue_tag = '0;
      unique case (state_ff)
         S_CONV: begin
            issue_tag.vld  = 1'b1;
            issue_tag.mode = M_CONV;
            issue_tag.dbl  = !(k_ff == '0 || k_last);
         end
         S_MASS: begin
            issue_tag.vld  = 1'b1;
            issue_tag.mode = M_MASS;
         end
         S_SCALE: begin
            issue_tag.vld   = 1'b1;
            issue_tag.mode  = M_SCALE;
            issue_tag.chunk = c_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      unique case (s1_ff.mode)
         M_CONV: begin
            mul_a = 33'(kern_rd_ff);
            mul_b = 33'(hist_rd_ff);
         end
         M_MASS: begin
            mul_a = 33'(am_rd_ff);
            mul_b = 33'(pa_rd_ff);
         end
         M_SCALE: begin
            mul_a = (s1_ff.chunk == 2'(NCH - 1)) ? 33'(signed'(chunk_ff))
                                                 : $signed({1'b0, chunk_ff});
            mul_b = $signed({1'b0, ts_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   rfc_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .a      (mul_a),
      .b      (mul_b),
      .tag_in (s1_ff),
      .p_ff   (prod),
      .tag_ff (s2_tag)
   );

   always_comb begin
      sh   = rnd_ff >>> (2 * FRAC_BITS + 1);
      all0 = (sh[TOT_W-1:31] == '0);
      all1 = (sh[TOT_W-1:31] == '1);
   end

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      head_in  = head_ff;
      head6_in = head6_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      r_in     = r_ff;
      r6_in    = r6_ff;
      c_in     = c_ff;
      kbase_in = kbase_ff;
      slot6_in = slot6_ff;
      acc_in   = acc_ff;
      tot_in   = tot_ff;
      rnd_in   = rnd_ff;
      res_in   = res_ff;
      sat_in   = sat_ff;

      if (s2_tag.vld) begin
         unique case (s2_tag.mode)
            M_CONV: acc_in = acc_ff + (s2_tag.dbl ? ACC_W'(prod) <<< 1 : ACC_W'(prod));
            M_MASS: tot_in = tot_ff + (TOT_W'(prod) <<< (FRAC_BITS + 1));
            M_SCALE: tot_in = tot_ff + (TOT_W'(prod) <<< (32 * s2_tag.chunk));
            default: ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (in_op)
                  OP_CLEAR: begin
                     fill_in = '0;
                     head_in = '0;
                  end
                  OP_MOTION: begin
                     if (in_col == 3'd5) begin
                        head_in  = head_nx;
                        head6_in = HAW'(32'(head_nx) * 6);
                        fill_in  = fill_nx;
                        n_in     = (fill_nx < len_c) ? fill_nx : len_c;
                        j_in     = '0;
                        state_in = S_PUSH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_PUSH: begin
            j_in = j_ff + 3'd1;
            if (j_ff == 3'd5) begin
               j_in     = '0;
               r_in     = '0;
               r6_in    = '0;
               k_in     = '0;
               kbase_in = '0;
               slot6_in = head6_ff;
               acc_in   = '0;
               tot_in   = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            j_in = j_ff + 3'd1;
            if (j_ff == 3'd5) begin
               j_in     = '0;
               k_in     = k_ff + TW'(1);
               kbase_in = kbase_ff + KAW'(36);
               slot6_in = (slot6_ff == '0) ? HAW'((MAX_TAPS - 1) * 6) : slot6_ff - HAW'(6);
               if (k_last) begin
                  state_in = S_MASS;
               end
            end
         end
         S_MASS: begin
            j_in = j_ff + 3'd1;
            if (j_ff == 3'd5) begin
               j_in     = '0;
               state_in = S_DRAIN_A;
            end
         end
         S_DRAIN_A: begin
            if (!pipe_busy) begin
               c_in     = '0;
               state_in = S_SCALE;
            end
         end
         S_SCALE: begin
            c_in = c_ff + 2'd1;
            if (c_ff == 2'(NCH - 1)) begin
               state_in = S_DRAIN_B;
            end
         end
         S_DRAIN_B: begin
            if (!pipe_busy) begin
               state_in = S_ROUND;
            end
         end
         S_ROUND: begin
            rnd_in   = (TOT_W'(1) <<< (2 * FRAC_BITS)) - tot_ff;
            state_in = S_SAT;
         end
         S_SAT: begin
            if (!sh[TOT_W-1] && !all0) begin
               res_in = 32'sh7FFFFFFF;
               sat_in = 1'b1;
            end else if (sh[TOT_W-1] && !all1) begin
               res_in = 32'sh80000000;
               sat_in = 1'b1;
            end else begin
               res_in = sh[31:0];
               sat_in = 1'b0;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (r_ff == 3'd5) begin
                  state_in = S_IDLE;
               end else begin
                  r_in     = r_ff + 3'd1;
                  r6_in    = r6_ff + 6'd6;
                  k_in     = '0;
                  j_in     = '0;
                  kbase_in = '0;
                  slot6_in = head6_ff;
                  acc_in   = '0;
                  tot_in   = '0;
                  state_in = S_CONV;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fill_ff  <= '0;
         head_ff  <= '0;
         s1_ff    <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         head_ff  <= head_in;
         s1_ff    <= issue_tag;
      end
      head6_ff <= head6_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      j_ff     <= j_in;
      r_ff     <= r_in;
      r6_ff    <= r6_in;
      c_ff     <= c_in;
      kbase_ff <= kbase_in;
      slot6_ff <= slot6_in;
      acc_ff   <= acc_in;
      tot_ff   <= tot_in;
      rnd_ff   <= rnd_in;
      res_ff   <= res_in;
      sat_ff   <= sat_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'd0, res_ff, r_ff};
   assign rsp_tuser  = sat_ff;
   assign rsp_tlast  = (r_ff == 3'd5);

endmodule
